// File: rtl/assert_macros.svh
// Assertion macros shared by the stream find-and-replace RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFR_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/sfr_pkg.sv
// Types and constants for the stream find-and-replace block.
// No dependencies; used by the interfaces and every module.
package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int REPL_MAX  = 8;
    localparam int RIDX_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES     = 2'd0,
        REG_PATTERN_LENGTH    = 2'd1,
        REG_REPLACEMENT_BYTES = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } text_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_present;
        logic              from_replacement;
        logic              last_of_text;
    } result_t;

    // Configuration as seen by the back end, lengths already clamped
    typedef struct packed {
        logic [CFG_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_len;
        logic [CFG_W-1:0] replacement_bytes;
        logic [LEN_W-1:0] replacement_len;
    } cfg_t;

    // Handshake between the input queue and the sequencer
    typedef struct packed {
        logic       valid;
        text_item_t item;
    } queue_head_t;

endpackage

// File: rtl/sfr_if.sv
// Stream interfaces for the find-and-replace block: text beats in, result beats out.
// Depends on sfr_pkg.
interface sfr_text_if;
    logic                            valid;
    logic                            ready;
    logic [sfr_pkg::BYTE_W-1:0]      text_byte;
    logic                            end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sfr_result_if;
    logic                            valid;
    logic                            ready;
    logic [sfr_pkg::BYTE_W-1:0]      out_byte;
    logic                            byte_present;
    logic                            from_replacement;
    logic                            last_of_text;

    modport source (output valid, output out_byte, output byte_present,
                    output from_replacement, output last_of_text, input ready);
    modport sink   (input valid, input out_byte, input byte_present,
                    input from_replacement, input last_of_text, output ready);
endinterface

// File: rtl/sfr_front.sv
// Front end: accepts text beats into a two-entry queue for the sequencer.
// Depends on sfr_pkg and sfr_if.
module sfr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    sfr_text_if.sink             text,
    input  logic                 q_pop,
    output sfr_pkg::queue_head_t q_head
);

    sfr_pkg::text_item_t mem_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          fill_reg, fill_next;
    logic                push;
    logic                pop;

    // Accept while a slot is free
    assign text.ready   = (fill_reg != 2'd2);
    assign push         = text.valid && text.ready;
    assign pop          = q_pop && (fill_reg != 2'd0);
    assign q_head.valid = (fill_reg != 2'd0);
    assign q_head.item  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the accepted beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].text_byte   <= text.text_byte;
            mem_reg[wr_ptr_reg].end_of_text <= text.end_of_text;
        end
    end

endmodule

// File: rtl/sfr_engine.sv
// Back end: holds candidate bytes, tests them against the pattern and emits
// released bytes, replacement bytes and the end marker. Depends on sfr_pkg, sfr_if and assert_macros.svh.
`include "assert_macros.svh"

module sfr_engine
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfr_pkg::cfg_t        cfg,
    input  sfr_pkg::queue_head_t q_head,
    output logic                 q_pop,
    sfr_result_if.source         result
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int HW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = sfr_pkg::LEN_W;
    localparam int RW = sfr_pkg::RIDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_END
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [RW-1:0]              ridx_reg, ridx_next;
    logic                       eot_reg, eot_next;
    logic                       pend_v_reg, pend_v_next;
    logic                       out_v_reg, out_v_next;
    sfr_pkg::result_t           pend_reg, pend_next;
    sfr_pkg::result_t           out_reg, out_next;
    logic [sfr_pkg::BYTE_W-1:0] hold_reg [MAX_PATTERN];
    logic [sfr_pkg::BYTE_W-1:0] hold_next [MAX_PATTERN];

    logic                       out_free;
    logic                       can_emit;
    logic [MAX_PATTERN-1:0]     match_ok;
    logic                       is_prefix;
    logic                       is_full;
    logic                       emit;
    sfr_pkg::result_t           emit_data;
    logic                       shift;

    assign out_free = !out_v_reg || result.ready;
    assign can_emit = !pend_v_reg || out_free;

    // Compare each held byte with the pattern byte at the same place
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            match_ok[i] = (i >= int'(count_reg))
                || (hold_reg[i] == cfg.pattern_bytes[sfr_pkg::BYTE_W*i +: sfr_pkg::BYTE_W]);
        end
    end

    assign is_prefix = (LW'(count_reg) <= cfg.pattern_len) && (&match_ok);
    assign is_full   = (LW'(count_reg) == cfg.pattern_len);

    // Sequence one item: append, scan, replace, end
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ridx_next   = ridx_reg;
        eot_next    = eot_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_data   = '0;
        shift       = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            hold_next[i] = hold_reg[i];
        end

        // Drop the output beat once taken
        if (out_v_reg && result.ready)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop = 1'b1;
                    hold_next[count_reg[HW-1:0]] = q_head.item.text_byte;
                    count_next = count_reg + CW'(1);
                    eot_next   = q_head.item.end_of_text;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_END;
                end
                else if (is_prefix)
                begin
                    if (is_full && (cfg.replacement_len != '0))
                    begin
                        ridx_next  = '0;
                        state_next = ST_REPL;
                    end
                    else
                    begin
                        if (is_full)
                        begin
                            count_next = '0;
                        end
                        state_next = ST_END;
                    end
                end
                else if (can_emit)
                begin
                    // Release the oldest held byte
                    emit       = 1'b1;
                    emit_data  = '{out_byte: hold_reg[0], byte_present: 1'b1,
                                   from_replacement: 1'b0, last_of_text: 1'b0};
                    shift      = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            ST_REPL:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_data = '{out_byte: cfg.replacement_bytes[sfr_pkg::BYTE_W*ridx_reg +:
                                                                  sfr_pkg::BYTE_W],
                                  byte_present: 1'b1, from_replacement: 1'b1,
                                  last_of_text: 1'b0};
                    ridx_next = ridx_reg + RW'(1);
                    if ({1'b0, ridx_reg} == cfg.replacement_len - LW'(1))
                    begin
                        count_next = '0;
                        state_next = ST_END;
                    end
                end
            end
            ST_END:
            begin
                if (eot_reg && (count_reg != '0))
                begin
                    // Flush the hold, oldest first
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        emit_data  = '{out_byte: hold_reg[0], byte_present: 1'b1,
                                       from_replacement: 1'b0, last_of_text: 1'b0};
                        shift      = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (eot_reg)
                begin
                    // Mark the final beat, or send a bare end marker
                    if (out_free)
                    begin
                        out_v_next = 1'b1;
                        if (pend_v_reg)
                        begin
                            out_next              = pend_reg;
                            out_next.last_of_text = 1'b1;
                        end
                        else
                        begin
                            out_next = '{out_byte: '0, byte_present: 1'b0,
                                         from_replacement: 1'b0, last_of_text: 1'b1};
                        end
                        pend_v_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
                else if (!pend_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next    = pend_reg;
                    out_v_next  = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Move the pending beat out and park the new one
        if (emit)
        begin
            if (pend_v_reg)
            begin
                out_next   = pend_reg;
                out_v_next = 1'b1;
            end
            pend_next   = emit_data;
            pend_v_next = 1'b1;
        end

        // Shift the hold down by one place
        if (shift)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                hold_next[i] = hold_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ridx_reg   <= '0;
            eot_reg    <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ridx_reg   <= ridx_next;
            eot_reg    <= eot_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            hold_reg[i] <= hold_next[i];
        end
    end

    assign result.valid            = out_v_reg;
    assign result.out_byte         = out_reg.out_byte;
    assign result.byte_present     = out_reg.byte_present;
    assign result.from_replacement = out_reg.from_replacement;
    assign result.last_of_text     = out_reg.last_of_text;

    // No beat is left pending between items
    `SFR_ASSERT(a_pend_flushed, state_reg == ST_IDLE, !pend_v_reg)
    // The hold always has room for the next byte between items
    `SFR_ASSERT(a_hold_room, state_reg == ST_IDLE, count_reg < CW'(MAX_PATTERN))
    // Closing a text puts a marked beat on the output and frees the sequencer
    `SFR_ASSERT_NEXT(a_last_ends_item,
        state_reg == ST_END && eot_reg && count_reg == '0 && out_free,
        state_reg == ST_IDLE && out_v_reg && out_reg.last_of_text)

endmodule

// File: rtl/stream_find_and_replace.sv
// Top level of the streaming find-and-replace block: configuration registers,
// input queue and match sequencer. Depends on sfr_pkg, sfr_if, sfr_front, sfr_engine.
//
//  channel  | dir | beat
//  ---------+-----+-------------------------------------------------------------
//  text     | in  | text_byte, end_of_text
//  result   | out | out_byte, byte_present, from_replacement, last_of_text
//  cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A byte that passes straight through is appended in ST_IDLE, released in ST_SCAN and
// sent out in ST_END; further released, replacement or flushed bytes go out one per
// cycle unless the output stalls, set by the shared prefix compare and output path.
// The input queue holds two beats, so text is taken while the sequencer works.
// The output register and one pending beat let results wait on a stalled sink.
// Reset is asynchronous; the text input is ready as soon as it is released.
module stream_find_and_replace
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]       cfg_data,
    sfr_text_if.sink                        text,
    sfr_result_if.source                    result
);

    localparam int LW = sfr_pkg::LEN_W;

    logic [sfr_pkg::CFG_W-1:0] pattern_bytes_reg;
    logic [LW-1:0]             pattern_length_reg;
    logic [sfr_pkg::CFG_W-1:0] replacement_bytes_reg;
    logic [LW-1:0]             replacement_length_reg;
    sfr_pkg::cfg_t             cfg;
    sfr_pkg::queue_head_t      q_head;
    logic                      q_pop;

    // Hold configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= LW'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (sfr_pkg::cfg_reg_t'(cfg_index))
                sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                sfr_pkg::REG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[LW-1:0];
                sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[LW-1:0];
                default:                         ;
            endcase
        end
    end

    // Clamp lengths into their usable ranges
    always_comb
    begin
        cfg.pattern_bytes     = pattern_bytes_reg;
        cfg.replacement_bytes = replacement_bytes_reg;
        if (pattern_length_reg == '0)
        begin
            cfg.pattern_len = LW'(1);
        end
        else if (pattern_length_reg > LW'(MAX_PATTERN))
        begin
            cfg.pattern_len = LW'(MAX_PATTERN);
        end
        else
        begin
            cfg.pattern_len = pattern_length_reg;
        end
        if (replacement_length_reg > LW'(sfr_pkg::REPL_MAX))
        begin
            cfg.replacement_len = LW'(sfr_pkg::REPL_MAX);
        end
        else
        begin
            cfg.replacement_len = replacement_length_reg;
        end
    end

    sfr_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    sfr_engine #(.MAX_PATTERN(MAX_PATTERN)) u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .q_head (q_head),
        .q_pop  (q_pop),
        .result (result)
    );

endmodule
